### rtl/core/lrb_pkg.sv
// Package for the lossy ring buffer: status codes, request and register
// codes, field widths and types. Depends on nothing.
`timescale 1ns / 1ps

package lrb_pkg;

  localparam int STATUS_WIDTH   = 3;
  localparam int POS_WIDTH      = 47;
  localparam int CNT_WIDTH      = 32;
  localparam int NUM_WIDTH      = 9;
  localparam int GAP_WIDTH      = 8;
  localparam int CFG_DATA_WIDTH = 9;
  localparam int CFG_IDX_WIDTH  = 1;
  localparam int N_MIN          = 3;

  typedef logic [STATUS_WIDTH-1:0]   status_t;
  typedef logic [POS_WIDTH-1:0]      pos_t;
  typedef logic [CNT_WIDTH-1:0]      cnt_t;
  typedef logic [NUM_WIDTH-1:0]      num_t;
  typedef logic [GAP_WIDTH-1:0]      gap_t;
  typedef logic [CFG_IDX_WIDTH-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_WIDTH-1:0] cfg_data_t;

  localparam status_t STATUS_OK          = 3'd0;
  localparam status_t STATUS_NOT_WRITTEN = 3'd1;
  localparam status_t STATUS_NOTHING_NEW = 3'd2;
  localparam status_t STATUS_UNDERFILLED = 3'd3;
  localparam status_t STATUS_OVERFLOW    = 3'd4;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam cfg_idx_t CFG_NUM_ELEMENTS = 1'b0;
  localparam cfg_idx_t CFG_READ_GAP     = 1'b1;

  localparam num_t NUM_RESET = 9'd256;
  localparam gap_t GAP_RESET = 8'd0;

  localparam pos_t POS_MAX = {POS_WIDTH{1'b1}};
  localparam cnt_t CNT_MAX = {CNT_WIDTH{1'b1}};

endpackage

### rtl/core/lrb_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### rtl/core/lrb_mod.sv
// Bit-serial remainder unit: floor modulo of a signed value by a small
// positive divisor, one quotient bit per cycle. No dependencies.
`timescale 1ns / 1ps

module lrb_mod #(
  parameter int VALUE_WIDTH = 49,
  parameter int DIV_WIDTH   = 9,
  parameter int RES_WIDTH   = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [DIV_WIDTH-1:0]   divisor,
  output logic                   done,
  output logic [RES_WIDTH-1:0]   residue
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] mag;
  logic [DIV_WIDTH-1:0]   rem;
  logic                   neg;
  logic [CW-1:0]          cnt;
  logic                   run;
  logic [DIV_WIDTH:0]     trial;
  logic [DIV_WIDTH-1:0]   rem_next;
  logic [DIV_WIDTH-1:0]   fixed;

  assign trial = {rem, mag[VALUE_WIDTH-1]};

  always_comb begin
    if (trial >= {1'b0, divisor}) begin
      rem_next = DIV_WIDTH'(trial - {1'b0, divisor});
    end else begin
      rem_next = DIV_WIDTH'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(VALUE_WIDTH);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // work on the magnitude, fold the sign back at the end
      mag <= value[VALUE_WIDTH-1] ? VALUE_WIDTH'(~value + VALUE_WIDTH'(1)) : value;
      neg <= value[VALUE_WIDTH-1];
      rem <= '0;
    end else if (run) begin
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign fixed   = (neg && rem != '0) ? DIV_WIDTH'(divisor - rem) : rem;
  assign residue = RES_WIDTH'(fixed);

endmodule

### rtl/core/lossy_ring_buffer_with_read_gap.sv
// Top level of the lossy overwriting ring buffer with a read gap.
// Uses lrb_pkg, lrb_ram (element store) and lrb_mod (slot remainder unit).
`timescale 1ns / 1ps

// Channel   Handshake         Payload
// input     start / busy      req_type, write_data
// result    done (1 cycle)    status, read_data, read_position, dropped_now,
//                             drop_total, not_written_count,
//                             nothing_new_count, underfilled_count
// config    cfg_write         cfg_index, cfg_data
//
// Each item passes the execute state, which decides it and addresses the element
// memory, and the done state, which shows the registered memory read; a new item
// is taken as its result shows. Slot numbers are kept as residues beside the
// indices. After a configuration write, busy stays high while the remainder unit
// rebuilds the residues of the write index, read index and gap.
// Reset is synchronous; the element memory is not cleared. Results are shown
// for one cycle and cannot be held off.

module lossy_ring_buffer_with_read_gap #(
  parameter int DEPTH       = 256,
  parameter int DATA_WIDTH  = 32,
  parameter int INDEX_WIDTH = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      req_type,
  input  logic [DATA_WIDTH-1:0]     write_data,
  output logic                      done,
  output lrb_pkg::status_t          status,
  output logic [DATA_WIDTH-1:0]     read_data,
  output lrb_pkg::pos_t             read_position,
  output lrb_pkg::pos_t             dropped_now,
  output lrb_pkg::cnt_t             drop_total,
  output lrb_pkg::cnt_t             not_written_count,
  output lrb_pkg::cnt_t             nothing_new_count,
  output lrb_pkg::cnt_t             underfilled_count,
  input  logic                      cfg_write,
  input  lrb_pkg::cfg_idx_t         cfg_index,
  input  lrb_pkg::cfg_data_t        cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = AW + 1;
  localparam int SW = INDEX_WIDTH + 1;

  localparam logic [SW-1:0] IDX_MAX_V = {1'b0, {INDEX_WIDTH{1'b1}}};
  localparam logic [SW-1:0] IDX_MIN_V = {1'b1, {INDEX_WIDTH{1'b0}}};

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_RES  = 2'd3;

  localparam logic [1:0] OP_LAST = 2'd0;
  localparam logic [1:0] OP_CUR  = 2'd1;
  localparam logic [1:0] OP_GAP  = 2'd2;

  logic [1:0] state;
  logic [1:0] op;
  logic       launch;
  logic       accept;

  lrb_pkg::num_t num_elements;
  lrb_pkg::gap_t read_gap;

  logic [INDEX_WIDTH-1:0] last_written;
  logic                   any_written;
  logic                   first_read_pending;
  logic [SW-1:0]          current_read;
  lrb_pkg::cnt_t          skip_total;
  lrb_pkg::cnt_t          count_no_write;
  lrb_pkg::cnt_t          count_no_new;
  lrb_pkg::cnt_t          count_underfill;
  logic [AW-1:0]          lw_res;
  logic [AW-1:0]          cur_res;
  logic [AW-1:0]          gap_res;

  logic                   req;
  logic [DATA_WIDTH-1:0]  data;
  logic                   rd_ok;

  // state-derived values, refreshed every cycle
  logic [SW-1:0]          pre_tail;
  logic [SW-1:0]          pre_ready;
  logic [SW-1:0]          pre_inc;
  logic [SW-1:0]          pre_skip;
  logic [INDEX_WIDTH-1:0] pre_lw_inc;
  logic                   pre_eq_ready;
  logic                   pre_lt_tail;
  logic                   pre_cur_max;
  logic                   pre_cur_pos;
  logic                   pre_lw_max;
  logic [AW-1:0]          pre_tail_res;
  logic [AW-1:0]          pre_ready_res;
  logic [AW-1:0]          pre_inc_res;
  logic [AW-1:0]          pre_wr_res;

  logic [31:0]   num_ext;
  logic [NW-1:0] n_eff;
  logic [SW-1:0] lw_s;
  logic [SW-1:0] tail_c;
  logic [SW-1:0] ready_c;
  logic [NW-1:0] tail_t;
  logic [NW-1:0] inc_t;
  logic [NW-1:0] wr_t;

  lrb_pkg::status_t       st_c;
  logic [SW-1:0]          rd_c;
  logic [AW-1:0]          rd_res_c;
  logic [INDEX_WIDTH-1:0] wr_idx_c;
  logic [AW-1:0]          wr_res_c;
  logic                   use_drop_c;
  logic                   rd_taken_c;
  logic                   ram_en;
  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [DATA_WIDTH-1:0]  ram_rdata;

  logic [63:0]   drop64;
  logic [32:0]   skip_sum;
  lrb_pkg::cnt_t skip_next;
  lrb_pkg::pos_t drop_sat;

  logic [SW-1:0] mod_value;
  logic          mod_done;
  logic [AW-1:0] mod_res;

  assign accept = start && !busy;
  assign busy   = (state == ST_EXEC) || (state == ST_RES);
  assign done   = (state == ST_DONE);

  // clamp the slot count to [3, DEPTH]
  assign num_ext = 32'(num_elements);
  always_comb begin
    if (num_ext < 32'(lrb_pkg::N_MIN)) begin
      n_eff = NW'(lrb_pkg::N_MIN);
    end else if (num_ext > 32'(DEPTH)) begin
      n_eff = NW'(DEPTH);
    end else begin
      n_eff = NW'(num_ext);
    end
  end

  assign lw_s    = {1'b0, last_written};
  assign tail_c  = lw_s - SW'(n_eff) + SW'(2);
  assign ready_c = lw_s - SW'(read_gap);
  assign tail_t  = NW'(lw_res) + NW'(2);
  assign inc_t   = NW'(cur_res) + NW'(1);
  assign wr_t    = NW'(lw_res) + NW'(1);

  always_ff @(posedge clk) begin
    pre_tail     <= tail_c;
    pre_ready    <= ready_c;
    pre_inc      <= current_read + SW'(1);
    pre_skip     <= lw_s - current_read - SW'(n_eff) + SW'(1);
    pre_lw_inc   <= last_written + INDEX_WIDTH'(1);
    pre_eq_ready <= (current_read == ready_c);
    pre_lt_tail  <= ($signed(current_read) < $signed(tail_c));
    pre_cur_max  <= (current_read == IDX_MAX_V);
    pre_cur_pos  <= ($signed(current_read) > $signed(SW'(0)));
    pre_lw_max   <= (last_written == {INDEX_WIDTH{1'b1}});
    pre_tail_res <= (tail_t >= n_eff) ? AW'(tail_t - n_eff) : AW'(tail_t);
    pre_inc_res  <= (inc_t == n_eff) ? '0 : AW'(inc_t);
    pre_wr_res   <= (wr_t == n_eff) ? '0 : AW'(wr_t);
    if (lw_res < gap_res) begin
      pre_ready_res <= AW'(NW'(lw_res) + n_eff - NW'(gap_res));
    end else begin
      pre_ready_res <= lw_res - gap_res;
    end
  end

  // decide the item in the execute cycle
  always_comb begin
    st_c       = lrb_pkg::STATUS_OK;
    rd_c       = pre_ready;
    rd_res_c   = pre_ready_res;
    wr_idx_c   = pre_lw_inc;
    wr_res_c   = pre_wr_res;
    use_drop_c = 1'b0;
    rd_taken_c = 1'b0;
    if (req == lrb_pkg::REQ_WRITE) begin
      if (!any_written) begin
        wr_idx_c = '0;
        wr_res_c = '0;
      end else if (pre_lw_max) begin
        st_c = lrb_pkg::STATUS_OVERFLOW;
      end
    end else begin
      if (!any_written) begin
        st_c = lrb_pkg::STATUS_NOT_WRITTEN;
      end else if (first_read_pending) begin
        rd_taken_c = 1'b1;
      end else if (pre_eq_ready || (!pre_lt_tail && pre_cur_max)) begin
        st_c = lrb_pkg::STATUS_NOTHING_NEW;
      end else if (pre_lt_tail) begin
        // fell behind tail: jump to it and, if the old read index was above zero, count the skipped indices
        rd_taken_c = 1'b1;
        rd_c       = pre_tail;
        rd_res_c   = pre_tail_res;
        use_drop_c = pre_cur_pos;
      end else begin
        rd_taken_c = 1'b1;
        rd_c       = pre_inc;
        rd_res_c   = pre_inc_res;
      end
      if (rd_taken_c && rd_c[SW-1]) begin
        st_c       = lrb_pkg::STATUS_UNDERFILLED;
        use_drop_c = 1'b0;
      end
    end
  end

  assign ram_we   = (state == ST_EXEC) && (req == lrb_pkg::REQ_WRITE)
                    && (st_c == lrb_pkg::STATUS_OK);
  assign ram_en   = ram_we || ((state == ST_EXEC) && (req == lrb_pkg::REQ_READ)
                    && (st_c == lrb_pkg::STATUS_OK));
  assign ram_addr = (req == lrb_pkg::REQ_WRITE) ? wr_res_c : rd_res_c;

  assign drop64    = use_drop_c ? 64'(pre_skip) : 64'd0;
  assign drop_sat  = (drop64 > 64'(lrb_pkg::POS_MAX)) ? lrb_pkg::POS_MAX
                                                     : lrb_pkg::pos_t'(drop64);
  assign skip_sum  = {1'b0, skip_total} + {1'b0, drop64[31:0]};
  assign skip_next = ((drop64[63:32] != '0) || skip_sum[32]) ? lrb_pkg::CNT_MAX
                                                               : skip_sum[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      op                 <= OP_LAST;
      launch             <= 1'b0;
      num_elements       <= lrb_pkg::NUM_RESET;
      read_gap           <= lrb_pkg::GAP_RESET;
      last_written       <= '0;
      any_written        <= 1'b0;
      first_read_pending <= 1'b1;
      current_read       <= IDX_MIN_V;
      skip_total         <= '0;
      count_no_write     <= '0;
      count_no_new       <= '0;
      count_underfill    <= '0;
      lw_res             <= '0;
      cur_res            <= '0;
      gap_res            <= '0;
      rd_ok              <= 1'b0;
    end else begin
      launch <= 1'b0;
      case (state)
        ST_IDLE, ST_DONE: begin
          state <= accept ? ST_EXEC : ST_IDLE;
        end
        ST_EXEC: begin
          state <= ST_DONE;
          rd_ok <= (req == lrb_pkg::REQ_READ) && (st_c == lrb_pkg::STATUS_OK);
          if (req == lrb_pkg::REQ_WRITE) begin
            if (st_c == lrb_pkg::STATUS_OK) begin
              last_written <= wr_idx_c;
              lw_res       <= wr_res_c;
              any_written  <= 1'b1;
            end
          end else begin
            if (!any_written) begin
              first_read_pending <= 1'b1;
            end else begin
              first_read_pending <= 1'b0;
            end
            if (rd_taken_c) begin
              current_read <= rd_c;
              cur_res      <= rd_res_c;
            end
            if (st_c == lrb_pkg::STATUS_NOT_WRITTEN && count_no_write != lrb_pkg::CNT_MAX) begin
              count_no_write <= count_no_write + lrb_pkg::cnt_t'(1);
            end
            if (st_c == lrb_pkg::STATUS_NOTHING_NEW && count_no_new != lrb_pkg::CNT_MAX) begin
              count_no_new <= count_no_new + lrb_pkg::cnt_t'(1);
            end
            if (st_c == lrb_pkg::STATUS_UNDERFILLED
                && count_underfill != lrb_pkg::CNT_MAX) begin
              count_underfill <= count_underfill + lrb_pkg::cnt_t'(1);
            end
            skip_total <= skip_next;
          end
        end
        ST_RES: begin
          if (mod_done) begin
            case (op)
              OP_LAST: lw_res  <= mod_res;
              OP_CUR:  cur_res <= mod_res;
              default: gap_res <= mod_res;
            endcase
            if (op == OP_GAP) begin
              state <= ST_IDLE;
            end else begin
              op     <= op + 2'd1;
              launch <= 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // a register write restarts the residue rebuild
      if (cfg_write) begin
        if (cfg_index == lrb_pkg::CFG_NUM_ELEMENTS) begin
          num_elements <= cfg_data;
        end else begin
          read_gap <= cfg_data[lrb_pkg::GAP_WIDTH-1:0];
        end
        state  <= ST_RES;
        op     <= OP_LAST;
        launch <= 1'b1;
      end
    end
  end

  // result payload, captured with the decision
  always_ff @(posedge clk) begin
    if (accept) begin
      req  <= req_type;
      data <= write_data;
    end
    if (state == ST_EXEC) begin
      status <= st_c;
      if ((req == lrb_pkg::REQ_READ) && (st_c == lrb_pkg::STATUS_OK)) begin
        read_position <= lrb_pkg::pos_t'(rd_c);
        dropped_now   <= drop_sat;
      end else begin
        read_position <= '0;
        dropped_now   <= '0;
      end
    end
  end

  assign read_data         = rd_ok ? ram_rdata : '0;
  assign drop_total        = skip_total;
  assign not_written_count = count_no_write;
  assign nothing_new_count = count_no_new;
  assign underfilled_count = count_underfill;

  always_comb begin
    case (op)
      OP_LAST: mod_value = lw_s;
      OP_CUR:  mod_value = current_read;
      default: mod_value = SW'(read_gap);
    endcase
  end

  lrb_mod #(
    .VALUE_WIDTH (SW),
    .DIV_WIDTH   (NW),
    .RES_WIDTH   (AW)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (launch),
    .value   (mod_value),
    .divisor (n_eff),
    .done    (mod_done),
    .residue (mod_res)
  );

  lrb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (data),
    .rdata (ram_rdata)
  );

endmodule

### sim/tb_lossy_ring_buffer_with_read_gap.sv
// Self-checking bench for lossy_ring_buffer_with_read_gap: directed and random
// writes and reads over many register settings, each reply checked in order.
// Depends on lrb_pkg and the RTL of the ring buffer.
`timescale 1ns / 1ps

module tb_lossy_ring_buffer_with_read_gap;
  import lrb_pkg::*;

  localparam int     DEPTH        = 256;
  localparam int     DATA_WIDTH   = 32;
  localparam int     INDEX_WIDTH  = 48;
  localparam int     LIMIT_CYCLES = 600000;
  localparam int     PHASE_ITEMS  = 80;
  localparam int     N_PHASES     = 16;
  localparam longint IDX_TOP      = (64'sd1 <<< INDEX_WIDTH) - 1;
  localparam longint IDX_BOTTOM   = -IDX_TOP - 1;
  localparam longint CNT_CEIL     = 64'sh0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic                  kind;
    logic [DATA_WIDTH-1:0] data;
  } request_t;

  typedef struct packed {
    status_t               status;
    logic [DATA_WIDTH-1:0] read_data;
    pos_t                  read_position;
    pos_t                  dropped_now;
    cnt_t                  drop_total;
    cnt_t                  not_written_count;
    cnt_t                  nothing_new_count;
    cnt_t                  underfilled_count;
  } reply_t;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  start      = 1'b0;
  logic                  req_type   = 1'b0;
  logic [DATA_WIDTH-1:0] write_data = '0;
  logic                  cfg_write  = 1'b0;
  cfg_idx_t              cfg_index  = CFG_NUM_ELEMENTS;
  cfg_data_t             cfg_data   = '0;
  logic                  busy;
  logic                  done;
  status_t               status;
  logic [DATA_WIDTH-1:0] read_data;
  pos_t                  read_position;
  pos_t                  dropped_now;
  cnt_t                  drop_total;
  cnt_t                  not_written_count;
  cnt_t                  nothing_new_count;
  cnt_t                  underfilled_count;

  lossy_ring_buffer_with_read_gap #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .req_type         (req_type),
    .write_data       (write_data),
    .done             (done),
    .status           (status),
    .read_data        (read_data),
    .read_position    (read_position),
    .dropped_now      (dropped_now),
    .drop_total       (drop_total),
    .not_written_count(not_written_count),
    .nothing_new_count(nothing_new_count),
    .underfilled_count(underfilled_count),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Shadow of the buffer state
  logic [DATA_WIDTH-1:0] slot_mem [DEPTH];
  longint                last_idx      = 0;
  bit                    any_written   = 1'b0;
  bit                    first_pending = 1'b1;
  longint                read_idx      = IDX_BOTTOM;
  longint                skip_sum      = 0;
  longint                no_write_cnt  = 0;
  longint                no_new_cnt    = 0;
  longint                underfill_cnt = 0;
  num_t                  num_cfg       = NUM_RESET;
  gap_t                  gap_cfg       = GAP_RESET;

  request_t request_q [$];
  reply_t   reply_q [$];
  request_t next_req;
  reply_t   want;
  bit       taken       = 1'b0;
  int       idle_pct    = 0;
  int       errors      = 0;
  int       cycles      = 0;
  int       writes_seen = 0;
  int       reads_seen  = 0;
  int       settings    = 0;
  int       status_seen [5];

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint bump(longint c);
    return (c < CNT_CEIL) ? c + 1 : CNT_CEIL;
  endfunction

  function automatic longint slots_used();
    longint n;
    n = longint'(num_cfg);
    if (n < N_MIN) n = N_MIN;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  function automatic reply_t serve_request(logic kind, logic [DATA_WIDTH-1:0] data);
    reply_t a;
    longint n, prev, tail, ready, rd, w, d;
    bit     stale;
    a     = '0;
    n     = slots_used();
    rd    = 0;
    stale = 1'b0;
    if (kind == REQ_WRITE) begin
      if (any_written && last_idx >= IDX_TOP) begin
        a.status = STATUS_OVERFLOW;
      end else begin
        w = any_written ? last_idx + 1 : 0;
        slot_mem[w % n] = data;
        last_idx    = w;
        any_written = 1'b1;
        a.status    = STATUS_OK;
      end
    end else if (!any_written) begin
      first_pending = 1'b1;
      no_write_cnt  = bump(no_write_cnt);
      a.status      = STATUS_NOT_WRITTEN;
    end else begin
      prev  = read_idx;
      tail  = last_idx - (n - 2);
      ready = last_idx - longint'(gap_cfg);
      if (first_pending) begin
        first_pending = 1'b0;
        prev = IDX_BOTTOM;
        rd   = ready;
      end else if (prev == ready || (prev >= tail && prev >= IDX_TOP)) begin
        stale = 1'b1;
      end else begin
        rd = (prev < tail) ? tail : prev + 1;
      end
      if (stale) begin
        no_new_cnt = bump(no_new_cnt);
        a.status   = STATUS_NOTHING_NEW;
      end else begin
        read_idx = rd;
        if (rd < 0) begin
          underfill_cnt = bump(underfill_cnt);
          a.status      = STATUS_UNDERFILLED;
        end else begin
          a.status        = STATUS_OK;
          a.read_data     = slot_mem[rd % n];
          a.read_position = rd[POS_WIDTH-1:0];
          // count skipped indices only once the reader has moved past zero
          if (prev > 0) begin
            d = rd - (prev + 1);
            a.dropped_now = (d > longint'(POS_MAX)) ? POS_MAX : d[POS_WIDTH-1:0];
            skip_sum = (skip_sum + d > CNT_CEIL) ? CNT_CEIL : skip_sum + d;
          end
        end
      end
    end
    a.drop_total        = skip_sum[CNT_WIDTH-1:0];
    a.not_written_count = no_write_cnt[CNT_WIDTH-1:0];
    a.nothing_new_count = no_new_cnt[CNT_WIDTH-1:0];
    a.underfilled_count = underfill_cnt[CNT_WIDTH-1:0];
    return a;
  endfunction

  task automatic check_field(string name, logic [63:0] got, logic [63:0] exp_val);
    if (got !== exp_val) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got);
    end
  endtask

  // Driver: hold an item until taken, then present the next one or idle
  always @(negedge clk) begin
    if (!rst && (!start || taken)) begin
      taken = 1'b0;
      if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_req = request_q.pop_front();
        start      <= 1'b1;
        req_type   <= next_req.kind;
        write_data <= next_req.data;
      end else begin
        start      <= 1'b0;
        req_type   <= 1'($urandom_range(1));
        write_data <= $urandom;
      end
    end
  end

  // Monitor: check replies, track register writes, predict taken items
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (reply_q.size() == 0) begin
          errors++;
          $display("%0t ns: reply with status %0d but no item outstanding", $time, status);
        end else begin
          want = reply_q.pop_front();
          check_field("status", status, want.status);
          check_field("read_data", read_data, want.read_data);
          check_field("read_position", read_position, want.read_position);
          check_field("dropped_now", dropped_now, want.dropped_now);
          check_field("drop_total", drop_total, want.drop_total);
          check_field("not_written_count", not_written_count, want.not_written_count);
          check_field("nothing_new_count", nothing_new_count, want.nothing_new_count);
          check_field("underfilled_count", underfilled_count, want.underfilled_count);
          if (want.status <= STATUS_OVERFLOW) status_seen[want.status]++;
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_NUM_ELEMENTS: num_cfg = cfg_data[NUM_WIDTH-1:0];
          CFG_READ_GAP:     gap_cfg = cfg_data[GAP_WIDTH-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        reply_q.push_back(serve_request(req_type, write_data));
        if (req_type == REQ_WRITE) writes_seen++;
        else reads_seen++;
        taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d items queued and %0d replies due",
               cycles, request_q.size(), reply_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void add_request(logic kind, logic [DATA_WIDTH-1:0] data);
    request_t r;
    r.kind = kind;
    r.data = data;
    request_q.push_back(r);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_data();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  task automatic settle();
    while (request_q.size() != 0 || reply_q.size() != 0 || start) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_registers(int num, int gap);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_NUM_ELEMENTS;
    cfg_data  <= cfg_data_t'(num);
    @(negedge clk);
    cfg_index <= CFG_READ_GAP;
    // bit 8 is not part of the gap register; toggle it anyway
    cfg_data  <= cfg_data_t'(($urandom_range(1) << GAP_WIDTH) | (gap & 8'hFF));
    @(negedge clk);
    cfg_write <= 1'b0;
    settings++;
  endtask

  // Bursts of writes followed by bursts of reads, with some stray items
  task automatic queue_traffic(int budget, int slots);
    int left, burst, i;
    left = budget;
    while (left > 0) begin
      if ($urandom_range(9) < 3) burst = $urandom_range(slots + 3);
      else burst = $urandom_range(6);
      for (i = 0; i < burst && left > 0; i++) begin
        add_request(REQ_WRITE, pick_data());
        left--;
      end
      burst = $urandom_range(1, 5);
      for (i = 0; i < burst && left > 0; i++) begin
        add_request(REQ_READ, $urandom);
        left--;
      end
      if (left > 0 && $urandom_range(9) == 0) begin
        add_request(1'($urandom_range(1)), pick_data());
        left--;
      end
    end
  endtask

  int phase_num [N_PHASES] = '{3, 3, 3, 0, 2, 4, 511, 256, 256, 17, 17, 300, 8, 5, 64, 1};
  int phase_gap [N_PHASES] = '{0, 1, 255, 0, 1, 2, 254, 254, 0, 15, 30, 100, 6, 3, 62, 200};

  initial begin
    int i, p, slots;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Keep the reader five behind so the first reads land below zero
    set_registers(256, 5);
    add_request(REQ_READ, 32'h0);
    add_request(REQ_READ, 32'hFFFF_FFFF);
    add_request(REQ_WRITE, 32'hFFFF_FFFF);
    add_request(REQ_WRITE, 32'h0000_0000);
    add_request(REQ_READ, 32'h0);
    add_request(REQ_READ, 32'h0);
    add_request(REQ_WRITE, 32'hAAAA_AAAA);
    add_request(REQ_WRITE, 32'h5555_5555);
    add_request(REQ_WRITE, 32'h8000_0000);
    add_request(REQ_WRITE, 32'h0000_0001);
    add_request(REQ_WRITE, 32'h7FFF_FFFF);
    add_request(REQ_WRITE, 32'hFFFF_FFFE);
    for (i = 0; i < 7; i++) add_request(REQ_READ, $urandom);
    settle();

    // Fill every slot once so no later setting can reach an unwritten entry
    for (i = 0; i < 264; i++) begin
      add_request(REQ_WRITE, pick_data());
      if (i % 8 == 7) add_request(REQ_READ, $urandom);
    end
    settle();

    for (p = 0; p < N_PHASES; p++) begin
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 74;
        default: idle_pct = 36;
      endcase
      set_registers(phase_num[p], phase_gap[p]);
      slots = phase_num[p];
      if (slots < N_MIN) slots = N_MIN;
      if (slots > DEPTH) slots = DEPTH;
      queue_traffic(PHASE_ITEMS, slots);
      settle();
    end
    repeat (20) @(posedge clk);

    $display("Ran %0d writes and %0d reads across %0d register settings in %0d cycles",
             writes_seen, reads_seen, settings, cycles);
    $display("Replies by status: ok %0d, not written %0d, nothing new %0d, underfilled %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d replies never arrived", errors, reply_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/lrb_pkg.sv
rtl/core/lrb_ram.sv
rtl/core/lrb_mod.sv
rtl/core/lossy_ring_buffer_with_read_gap.sv
sim/tb_lossy_ring_buffer_with_read_gap.sv
